>>> sv/cone_membership_pixel_test_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cone membership pixel test
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CONE_MEMBERSHIP_PIXEL_TEST_ASSERT_SVH
`define CONE_MEMBERSHIP_PIXEL_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMPT_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cone membership check failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define CMPT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cone membership check failed: next-cycle rule");

`endif

>>> sv/cmpt_pkg.sv
// ---------------------------------------------------------------------------
// Cone membership pixel test package
// Widths, reset values, register indexes and the configuration record.
// ---------------------------------------------------------------------------
package cmpt_pkg;

    localparam int COORD_BITS     = 24;
    localparam int COS_BITS       = 17;
    localparam int COS_ONE_SHIFT  = 16;
    localparam int LABEL_BITS_DEF = 4;
    localparam int NUM_STAGES     = 9;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = (COORD_BITS > COS_BITS) ? COORD_BITS : COS_BITS;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = DIFF_W + COORD_BITS;
    localparam int SQF_W   = 2 * DIFF_W;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int SUM_W   = PROD_W + 2;
    localparam int NORM_W  = SQ_W + 2;
    localparam int LIMB_W  = NORM_W / 2;
    localparam int DD_W    = 2 * LIMB_W;
    localparam int LHS_W   = 4 * LIMB_W;
    localparam int CNP_W   = COS_BITS + LIMB_W;
    localparam int CN_W    = COS_BITS + NORM_W;
    localparam int C2_W    = CN_W - 2 * LIMB_W;
    localparam int NP_W    = 2 * LIMB_W;
    localparam int N2P_W   = C2_W + LIMB_W;
    localparam int R_W     = CN_W + LIMB_W + 1;
    localparam int RHS_W   = CN_W + NORM_W + 1;

    localparam logic [COORD_BITS-1:0] AXIS_X_RST = COORD_BITS'(4096);
    localparam logic [COS_BITS-1:0]   COS_SQ_RST = COS_BITS'(54681);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_APEX_X  = 3'd0,
        CFG_APEX_Y  = 3'd1,
        CFG_APEX_Z  = 3'd2,
        CFG_AXIS_X  = 3'd3,
        CFG_AXIS_Y  = 3'd4,
        CFG_AXIS_Z  = 3'd5,
        CFG_COS_SQ  = 3'd6,
        CFG_PLANE_X = 3'd7
    } cmpt_cfg_idx_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] apex_x;
        logic [COORD_BITS-1:0] apex_y;
        logic [COORD_BITS-1:0] apex_z;
        logic [COORD_BITS-1:0] axis_x;
        logic [COORD_BITS-1:0] axis_y;
        logic [COORD_BITS-1:0] axis_z;
        logic [COS_BITS-1:0]   cos_sq;
        logic [COORD_BITS-1:0] plane_x;
    } cmpt_cfg_t;

endpackage

>>> sv/cmpt_datapath.sv
// ---------------------------------------------------------------------------
// Cone membership datapath
// Nine register stages computing the exact squared-cosine comparison.
// ---------------------------------------------------------------------------
module cmpt_datapath #(
    parameter int LABEL_BITS = cmpt_pkg::LABEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic [cmpt_pkg::NUM_STAGES-1:0]     stage_en,
    input  cmpt_pkg::cmpt_cfg_t                 cfg,
    input  logic [cmpt_pkg::COORD_BITS-1:0]     pos_y,
    input  logic [cmpt_pkg::COORD_BITS-1:0]     pos_z,
    input  logic [LABEL_BITS-1:0]               label,
    output logic                                inside_res,
    output logic [LABEL_BITS-1:0]               label_out
);

    localparam int CB     = cmpt_pkg::COORD_BITS;
    localparam int DIFF_W = cmpt_pkg::DIFF_W;
    localparam int PROD_W = cmpt_pkg::PROD_W;
    localparam int SQF_W  = cmpt_pkg::SQF_W;
    localparam int SQ_W   = cmpt_pkg::SQ_W;
    localparam int SUM_W  = cmpt_pkg::SUM_W;
    localparam int NORM_W = cmpt_pkg::NORM_W;
    localparam int LIMB_W = cmpt_pkg::LIMB_W;
    localparam int DD_W   = cmpt_pkg::DD_W;
    localparam int LHS_W  = cmpt_pkg::LHS_W;
    localparam int CNP_W  = cmpt_pkg::CNP_W;
    localparam int CN_W   = cmpt_pkg::CN_W;
    localparam int C2_W   = cmpt_pkg::C2_W;
    localparam int NP_W   = cmpt_pkg::NP_W;
    localparam int N2P_W  = cmpt_pkg::N2P_W;
    localparam int R_W    = cmpt_pkg::R_W;
    localparam int RHS_W  = cmpt_pkg::RHS_W;
    localparam int COS_W  = cmpt_pkg::COS_BITS;
    localparam int NST    = cmpt_pkg::NUM_STAGES;

    // Stage 0: difference vector and sampled axis.
    logic signed [DIFF_W-1:0] s0_vx_reg, s0_vy_reg, s0_vz_reg;
    logic signed [DIFF_W-1:0] s0_vx_next, s0_vy_next, s0_vz_next;
    logic signed [CB-1:0]     s0_ax_reg, s0_ay_reg, s0_az_reg;
    logic [COS_W-1:0]         s0_cos_reg;

    // Stage 1: component products.
    logic signed [PROD_W-1:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic signed [PROD_W-1:0] s1_px_next, s1_py_next, s1_pz_next;
    logic signed [SQF_W-1:0]  sqv_x, sqv_y, sqv_z;
    logic signed [SQ_W-1:0]   sqa_x, sqa_y, sqa_z;
    logic [SQ_W-1:0]          s1_svx_reg, s1_svy_reg, s1_svz_reg;
    logic [SQ_W-1:0]          s1_sax_reg, s1_say_reg, s1_saz_reg;
    logic [COS_W-1:0]         s1_cos_reg;

    // Stage 2: dot product and squared norms.
    logic signed [SUM_W-1:0]  s2_dot_reg, s2_dot_next;
    logic [NORM_W-1:0]        s2_nv_reg, s2_nv_next;
    logic [NORM_W-1:0]        s2_na_reg, s2_na_next;
    logic [COS_W-1:0]         s2_cos_reg;

    // Stage 3: limb products of dot squared and cos times |v|^2.
    logic                     s3_pos_next;
    logic [LIMB_W-1:0]        dot_hi, dot_lo, nv_hi, nv_lo;
    logic [DD_W-1:0]          s3_ddhh_reg, s3_ddhl_reg, s3_ddll_reg;
    logic [DD_W-1:0]          s3_ddhh_next, s3_ddhl_next, s3_ddll_next;
    logic [CNP_W-1:0]         s3_cnh_reg, s3_cnl_reg, s3_cnh_next, s3_cnl_next;
    logic [NORM_W-1:0]        s3_na_reg;

    // Stage 4: dot squared and cos times |v|^2 assembled.
    logic [LHS_W-1:0]         s4_lhs_next;
    logic [CN_W-1:0]          s4_cn_reg, s4_cn_next;
    logic [NORM_W-1:0]        s4_na_reg;

    // Stage 5: limb products of the right-hand side.
    logic [LIMB_W-1:0]        cn0, cn1, na0, na1;
    logic [C2_W-1:0]          cn2;
    logic [NP_W-1:0]          s5_p00_reg, s5_p10_reg, s5_p01_reg, s5_p11_reg;
    logic [NP_W-1:0]          s5_p00_next, s5_p10_next, s5_p01_next, s5_p11_next;
    logic [N2P_W-1:0]         s5_p20_reg, s5_p21_reg, s5_p20_next, s5_p21_next;

    // Stage 6 and 7: right-hand side sums.
    logic [R_W-1:0]           s6_r0_reg, s6_r1_reg, s6_r0_next, s6_r1_next;
    logic [RHS_W-1:0]         s7_rhs_reg, s7_rhs_next;

    // Stage 8: result word.
    logic                     out_inside_reg, out_inside_next;
    logic [LABEL_BITS-1:0]    out_label_reg, out_label_next;

    // Values that travel alongside the arithmetic.
    logic [LABEL_BITS-1:0]    label_reg [0:NST-2];
    logic                     pos_reg   [3:NST-2];
    logic [LHS_W-1:0]         lhs_reg   [4:NST-2];

    always_comb
    begin
        s0_vx_next = DIFF_W'($signed(cfg.plane_x)) - DIFF_W'($signed(cfg.apex_x));
        s0_vy_next = DIFF_W'($signed(pos_y)) - DIFF_W'($signed(cfg.apex_y));
        s0_vz_next = DIFF_W'($signed(pos_z)) - DIFF_W'($signed(cfg.apex_z));

        s1_px_next = PROD_W'(s0_vx_reg) * PROD_W'(s0_ax_reg);
        s1_py_next = PROD_W'(s0_vy_reg) * PROD_W'(s0_ay_reg);
        s1_pz_next = PROD_W'(s0_vz_reg) * PROD_W'(s0_az_reg);
        sqv_x      = SQF_W'(s0_vx_reg) * SQF_W'(s0_vx_reg);
        sqv_y      = SQF_W'(s0_vy_reg) * SQF_W'(s0_vy_reg);
        sqv_z      = SQF_W'(s0_vz_reg) * SQF_W'(s0_vz_reg);
        sqa_x      = SQ_W'(s0_ax_reg) * SQ_W'(s0_ax_reg);
        sqa_y      = SQ_W'(s0_ay_reg) * SQ_W'(s0_ay_reg);
        sqa_z      = SQ_W'(s0_az_reg) * SQ_W'(s0_az_reg);

        s2_dot_next = SUM_W'(s1_px_reg) + SUM_W'(s1_py_reg) + SUM_W'(s1_pz_reg);
        s2_nv_next  = NORM_W'(s1_svx_reg) + NORM_W'(s1_svy_reg) + NORM_W'(s1_svz_reg);
        s2_na_next  = NORM_W'(s1_sax_reg) + NORM_W'(s1_say_reg) + NORM_W'(s1_saz_reg);

        s3_pos_next  = !s2_dot_reg[SUM_W-1] && (s2_dot_reg != '0);
        dot_hi       = s2_dot_reg[2*LIMB_W-1:LIMB_W];
        dot_lo       = s2_dot_reg[LIMB_W-1:0];
        nv_hi        = s2_nv_reg[2*LIMB_W-1:LIMB_W];
        nv_lo        = s2_nv_reg[LIMB_W-1:0];
        s3_ddhh_next = DD_W'(dot_hi) * DD_W'(dot_hi);
        s3_ddhl_next = DD_W'(dot_hi) * DD_W'(dot_lo);
        s3_ddll_next = DD_W'(dot_lo) * DD_W'(dot_lo);
        s3_cnh_next  = CNP_W'(s2_cos_reg) * CNP_W'(nv_hi);
        s3_cnl_next  = CNP_W'(s2_cos_reg) * CNP_W'(nv_lo);

        s4_lhs_next = (LHS_W'(s3_ddhh_reg) << (2 * LIMB_W))
                    + (LHS_W'(s3_ddhl_reg) << (LIMB_W + 1))
                    + LHS_W'(s3_ddll_reg);
        s4_cn_next  = (CN_W'(s3_cnh_reg) << LIMB_W) + CN_W'(s3_cnl_reg);

        cn0         = s4_cn_reg[LIMB_W-1:0];
        cn1         = s4_cn_reg[2*LIMB_W-1:LIMB_W];
        cn2         = s4_cn_reg[CN_W-1:2*LIMB_W];
        na0         = s4_na_reg[LIMB_W-1:0];
        na1         = s4_na_reg[2*LIMB_W-1:LIMB_W];
        s5_p00_next = NP_W'(cn0) * NP_W'(na0);
        s5_p10_next = NP_W'(cn1) * NP_W'(na0);
        s5_p20_next = N2P_W'(cn2) * N2P_W'(na0);
        s5_p01_next = NP_W'(cn0) * NP_W'(na1);
        s5_p11_next = NP_W'(cn1) * NP_W'(na1);
        s5_p21_next = N2P_W'(cn2) * N2P_W'(na1);

        s6_r0_next = (R_W'(s5_p20_reg) << (2 * LIMB_W)) + (R_W'(s5_p10_reg) << LIMB_W)
                   + R_W'(s5_p00_reg);
        s6_r1_next = (R_W'(s5_p21_reg) << (2 * LIMB_W)) + (R_W'(s5_p11_reg) << LIMB_W)
                   + R_W'(s5_p01_reg);

        s7_rhs_next = (RHS_W'(s6_r1_reg) << LIMB_W) + RHS_W'(s6_r0_reg);

        out_inside_next = pos_reg[NST-2]
                       && ((RHS_W'(lhs_reg[NST-2]) << cmpt_pkg::COS_ONE_SHIFT) > s7_rhs_reg);
        out_label_next  = out_inside_next ? label_reg[NST-2] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s0_vx_reg    <= s0_vx_next;
            s0_vy_reg    <= s0_vy_next;
            s0_vz_reg    <= s0_vz_next;
            s0_ax_reg    <= $signed(cfg.axis_x);
            s0_ay_reg    <= $signed(cfg.axis_y);
            s0_az_reg    <= $signed(cfg.axis_z);
            s0_cos_reg   <= cfg.cos_sq;
            label_reg[0] <= label;
        end
        if (stage_en[1])
        begin
            s1_px_reg    <= s1_px_next;
            s1_py_reg    <= s1_py_next;
            s1_pz_reg    <= s1_pz_next;
            s1_svx_reg   <= sqv_x[SQ_W-1:0];
            s1_svy_reg   <= sqv_y[SQ_W-1:0];
            s1_svz_reg   <= sqv_z[SQ_W-1:0];
            s1_sax_reg   <= $unsigned(sqa_x);
            s1_say_reg   <= $unsigned(sqa_y);
            s1_saz_reg   <= $unsigned(sqa_z);
            s1_cos_reg   <= s0_cos_reg;
            label_reg[1] <= label_reg[0];
        end
        if (stage_en[2])
        begin
            s2_dot_reg   <= s2_dot_next;
            s2_nv_reg    <= s2_nv_next;
            s2_na_reg    <= s2_na_next;
            s2_cos_reg   <= s1_cos_reg;
            label_reg[2] <= label_reg[1];
        end
        if (stage_en[3])
        begin
            pos_reg[3]   <= s3_pos_next;
            s3_ddhh_reg  <= s3_ddhh_next;
            s3_ddhl_reg  <= s3_ddhl_next;
            s3_ddll_reg  <= s3_ddll_next;
            s3_cnh_reg   <= s3_cnh_next;
            s3_cnl_reg   <= s3_cnl_next;
            s3_na_reg    <= s2_na_reg;
            label_reg[3] <= label_reg[2];
        end
        if (stage_en[4])
        begin
            pos_reg[4]   <= pos_reg[3];
            lhs_reg[4]   <= s4_lhs_next;
            s4_cn_reg    <= s4_cn_next;
            s4_na_reg    <= s3_na_reg;
            label_reg[4] <= label_reg[3];
        end
        if (stage_en[5])
        begin
            pos_reg[5]   <= pos_reg[4];
            lhs_reg[5]   <= lhs_reg[4];
            s5_p00_reg   <= s5_p00_next;
            s5_p10_reg   <= s5_p10_next;
            s5_p20_reg   <= s5_p20_next;
            s5_p01_reg   <= s5_p01_next;
            s5_p11_reg   <= s5_p11_next;
            s5_p21_reg   <= s5_p21_next;
            label_reg[5] <= label_reg[4];
        end
        if (stage_en[6])
        begin
            pos_reg[6]   <= pos_reg[5];
            lhs_reg[6]   <= lhs_reg[5];
            s6_r0_reg    <= s6_r0_next;
            s6_r1_reg    <= s6_r1_next;
            label_reg[6] <= label_reg[5];
        end
        if (stage_en[7])
        begin
            pos_reg[7]   <= pos_reg[6];
            lhs_reg[7]   <= lhs_reg[6];
            s7_rhs_reg   <= s7_rhs_next;
            label_reg[7] <= label_reg[6];
        end
        if (stage_en[8])
        begin
            out_inside_reg <= out_inside_next;
            out_label_reg  <= out_label_next;
        end
    end

    assign inside_res = out_inside_reg;
    assign label_out  = out_label_reg;

endmodule

>>> sv/cone_membership_pixel_test.sv
// ---------------------------------------------------------------------------
// Cone membership pixel test
// Decides whether each pixel centre lies strictly inside a configured cone.
// ---------------------------------------------------------------------------
// One word is accepted per clock cycle when the output side keeps up. The
// latency is set by the exact comparison of dot(v, D)^2 against cos^2 *
// |v|^2 * |D|^2: the wide products are built from 25-bit limb multiplies
// spread over nine register stages. Each stage holds its word until the
// next one frees, so a stall on the output side fills the bubbles before
// the input side is held off.
module cone_membership_pixel_test #(
    parameter int LABEL_BITS = cmpt_pkg::LABEL_BITS_DEF,
    localparam int S_DATA_W  = ((2 * cmpt_pkg::COORD_BITS + LABEL_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((1 + LABEL_BITS + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [cmpt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [cmpt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: pos_y, pos_z, label, zero padding.
    input  logic [S_DATA_W-1:0]                  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: inside_res, label_out, zero padding.
    output logic [M_DATA_W-1:0]                  m_axis_tdata
);

    `include "cone_membership_pixel_test_assert.svh"

    localparam int CB  = cmpt_pkg::COORD_BITS;
    localparam int NST = cmpt_pkg::NUM_STAGES;

    cmpt_pkg::cmpt_cfg_t    cfg_reg, cfg_next;
    logic [NST-1:0]         valid_reg, valid_next;
    logic [NST-1:0]         stage_en;
    logic                   inside_res;
    logic [LABEL_BITS-1:0]  label_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cmpt_pkg::cmpt_cfg_idx_t'(cfg_index))
                cmpt_pkg::CFG_APEX_X:  cfg_next.apex_x  = cfg_data[CB-1:0];
                cmpt_pkg::CFG_APEX_Y:  cfg_next.apex_y  = cfg_data[CB-1:0];
                cmpt_pkg::CFG_APEX_Z:  cfg_next.apex_z  = cfg_data[CB-1:0];
                cmpt_pkg::CFG_AXIS_X:  cfg_next.axis_x  = cfg_data[CB-1:0];
                cmpt_pkg::CFG_AXIS_Y:  cfg_next.axis_y  = cfg_data[CB-1:0];
                cmpt_pkg::CFG_AXIS_Z:  cfg_next.axis_z  = cfg_data[CB-1:0];
                cmpt_pkg::CFG_COS_SQ:  cfg_next.cos_sq  = cfg_data[cmpt_pkg::COS_BITS-1:0];
                cmpt_pkg::CFG_PLANE_X: cfg_next.plane_x = cfg_data[CB-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // A stage may load when it is empty or when its word moves on.
    always_comb
    begin
        stage_en[NST-1] = !valid_reg[NST-1] || m_axis_tready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next[0] = stage_en[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.apex_x  <= '0;
            cfg_reg.apex_y  <= '0;
            cfg_reg.apex_z  <= '0;
            cfg_reg.axis_x  <= cmpt_pkg::AXIS_X_RST;
            cfg_reg.axis_y  <= '0;
            cfg_reg.axis_z  <= '0;
            cfg_reg.cos_sq  <= cmpt_pkg::COS_SQ_RST;
            cfg_reg.plane_x <= '0;
            valid_reg       <= '0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            valid_reg <= valid_next;
        end
    end

    cmpt_datapath #(
        .LABEL_BITS (LABEL_BITS)
    ) u_datapath (
        .clk        (clk),
        .stage_en   (stage_en),
        .cfg        (cfg_reg),
        .pos_y      (s_axis_tdata[CB-1:0]),
        .pos_z      (s_axis_tdata[2*CB-1:CB]),
        .label      (s_axis_tdata[2*CB+LABEL_BITS-1:2*CB]),
        .inside_res (inside_res),
        .label_out  (label_out)
    );

    always_comb
    begin
        m_axis_tdata               = '0;
        m_axis_tdata[0]            = inside_res;
        m_axis_tdata[LABEL_BITS:1] = label_out;
    end

    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = valid_reg[NST-1];

    `CMPT_ASSERT_SAME(a_hold_only_when_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    `CMPT_ASSERT_NEXT(a_accept_enters_pipe, s_axis_tvalid && s_axis_tready, valid_reg[0])
    `CMPT_ASSERT_SAME(a_outside_no_label, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[LABEL_BITS:1] == '0)

endmodule

>>> tb/cone_membership_pixel_test_tb.sv
// ---------------------------------------------------------------------------
// Cone membership pixel test: self-checking testbench
// Loads a series of cone settings through the configuration port, streams
// pixel centres into the block and checks every result word against an
// exact wide-integer prediction of the inside test, with random gaps and
// stalls on both stream sides.
// ---------------------------------------------------------------------------

class cone_scoreboard #(int LW = 4, int OW = 8);

    typedef struct packed {
        logic          in_cone;
        logic [LW-1:0] label;
        int            seq;
    } pixel_result_t;

    pixel_result_t pending_results[$];
    int            errors;
    int            words_in;
    int            inside_words;
    int            outside_words;

    function new();
        errors        = 0;
        words_in      = 0;
        inside_words  = 0;
        outside_words = 0;
    endfunction

    function int pending_count();
        return pending_results.size();
    endfunction

    function void note_word(logic in_cone, logic [LW-1:0] label);
        pixel_result_t r;
        r.in_cone = in_cone;
        r.label   = in_cone ? label : '0;
        r.seq     = words_in;
        words_in++;
        pending_results.push_back(r);
    endfunction

    task report(string msg);
        if (errors < 40)
            $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task check_word(logic [OW-1:0] word);
        pixel_result_t want;
        if (pending_results.size() == 0)
        begin
            report($sformatf("result word %h arrived with no pixel outstanding", word));
            return;
        end
        want = pending_results.pop_front();
        if (want.in_cone)
            inside_words++;
        else
            outside_words++;
        if (word[0] !== want.in_cone)
            report($sformatf("pixel %0d: inside_res %b, predicted %b",
                             want.seq, word[0], want.in_cone));
        if (word[LW:1] !== want.label)
            report($sformatf("pixel %0d: label_out %0d, predicted %0d",
                             want.seq, word[LW:1], want.label));
        if (word[OW-1:LW+1] !== '0)
            report($sformatf("pixel %0d: padding bits %b not zero",
                             want.seq, word[OW-1:LW+1]));
    endtask

endclass

module cone_membership_pixel_test_tb;

    localparam int COORD_BITS    = cmpt_pkg::COORD_BITS;
    localparam int COS_BITS      = cmpt_pkg::COS_BITS;
    localparam int COS_ONE_SHIFT = cmpt_pkg::COS_ONE_SHIFT;
    localparam int CFG_IDX_BITS  = cmpt_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS = cmpt_pkg::CFG_DATA_BITS;
    localparam int NUM_STAGES    = cmpt_pkg::NUM_STAGES;

    localparam int LABEL_W      = cmpt_pkg::LABEL_BITS_DEF;
    localparam int IN_W         = ((2 * COORD_BITS + LABEL_W + 7) / 8) * 8;
    localparam int OUT_W        = ((1 + LABEL_W + 7) / 8) * 8;
    localparam int TOTAL_PIXELS = 1450;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data      = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_W-1:0]          s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_W-1:0]         m_axis_tdata;

    cone_scoreboard #(LABEL_W, OUT_W) sb;

    cmpt_pkg::cmpt_cfg_t cone_cfg;
    longint    aim_y;
    longint    aim_z;
    longint    spread;
    int        send_mode;
    int        recv_mode;
    int        hold_request;
    int        cone_settings;
    int        cycle_count;

    cone_membership_pixel_test #(.LABEL_BITS(LABEL_W)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.pending_count());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Strict inside test in exact integer arithmetic: the products stay
    // below 2^116, so 128-bit unsigned vectors hold them without loss.
    function automatic logic pixel_inside(logic [COORD_BITS-1:0] py,
                                          logic [COORD_BITS-1:0] pz);
        longint      vx, vy, vz, dx, dy, dz, dot;
        logic [127:0] dot_w, norm_v, norm_d, lhs, rhs;
        vx = longint'(signed'(cone_cfg.plane_x)) - longint'(signed'(cone_cfg.apex_x));
        vy = longint'(signed'(py)) - longint'(signed'(cone_cfg.apex_y));
        vz = longint'(signed'(pz)) - longint'(signed'(cone_cfg.apex_z));
        dx = longint'(signed'(cone_cfg.axis_x));
        dy = longint'(signed'(cone_cfg.axis_y));
        dz = longint'(signed'(cone_cfg.axis_z));
        dot = vx * dx + vy * dy + vz * dz;
        if (dot <= 0)
            return 1'b0;
        dot_w  = 128'(dot);
        norm_v = 128'(vx * vx) + 128'(vy * vy) + 128'(vz * vz);
        norm_d = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
        lhs    = (dot_w * dot_w) << COS_ONE_SHIFT;
        rhs    = 128'(cone_cfg.cos_sq) * norm_v * norm_d;
        return lhs > rhs;
    endfunction

    function automatic int draw_wait(int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 16);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endfunction

    function automatic longint rand_signed(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic logic [COORD_BITS-1:0] extreme_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return '1;
            4:       return COORD_BITS'(1);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // The bits above the cos-squared field are sometimes filled with noise,
    // which the block must ignore.
    function automatic logic [CFG_DATA_BITS-1:0] pick_cos_word();
        logic [COS_BITS-1:0]      c;
        logic [CFG_DATA_BITS-1:0] w;
        case ($urandom_range(0, 7))
            0:       c = '0;
            1:       c = COS_BITS'(65536);
            2:       c = COS_BITS'(65535);
            3:       c = COS_BITS'($urandom_range(65537, 131071));
            default: c = COS_BITS'($urandom_range(0, 65536));
        endcase
        w = CFG_DATA_BITS'(c);
        if ($urandom_range(0, 3) == 0)
            w[CFG_DATA_BITS-1:COS_BITS] = (CFG_DATA_BITS - COS_BITS)'($urandom);
        return w;
    endfunction

    task automatic write_reg(cmpt_pkg::cmpt_cfg_idx_t idx,
                             logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            cmpt_pkg::CFG_APEX_X:  cone_cfg.apex_x  = value[COORD_BITS-1:0];
            cmpt_pkg::CFG_APEX_Y:  cone_cfg.apex_y  = value[COORD_BITS-1:0];
            cmpt_pkg::CFG_APEX_Z:  cone_cfg.apex_z  = value[COORD_BITS-1:0];
            cmpt_pkg::CFG_AXIS_X:  cone_cfg.axis_x  = value[COORD_BITS-1:0];
            cmpt_pkg::CFG_AXIS_Y:  cone_cfg.axis_y  = value[COORD_BITS-1:0];
            cmpt_pkg::CFG_AXIS_Z:  cone_cfg.axis_z  = value[COORD_BITS-1:0];
            cmpt_pkg::CFG_COS_SQ:  cone_cfg.cos_sq  = value[COS_BITS-1:0];
            cmpt_pkg::CFG_PLANE_X: cone_cfg.plane_x = value[COORD_BITS-1:0];
            default:     ;
        endcase
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_count() != 0);
    endtask

    task automatic load_cone(logic [COORD_BITS-1:0] apx, logic [COORD_BITS-1:0] apy,
                             logic [COORD_BITS-1:0] apz, logic [COORD_BITS-1:0] axx,
                             logic [COORD_BITS-1:0] axy, logic [COORD_BITS-1:0] axz,
                             logic [CFG_DATA_BITS-1:0] cos_word,
                             logic [COORD_BITS-1:0] plx);
        pause_until_drained();
        write_reg(cmpt_pkg::CFG_APEX_X, CFG_DATA_BITS'(apx));
        write_reg(cmpt_pkg::CFG_APEX_Y, CFG_DATA_BITS'(apy));
        write_reg(cmpt_pkg::CFG_APEX_Z, CFG_DATA_BITS'(apz));
        write_reg(cmpt_pkg::CFG_AXIS_X, CFG_DATA_BITS'(axx));
        write_reg(cmpt_pkg::CFG_AXIS_Y, CFG_DATA_BITS'(axy));
        write_reg(cmpt_pkg::CFG_AXIS_Z, CFG_DATA_BITS'(axz));
        write_reg(cmpt_pkg::CFG_COS_SQ, cos_word);
        write_reg(cmpt_pkg::CFG_PLANE_X, CFG_DATA_BITS'(plx));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cone_settings++;
    endtask

    task automatic send_word(logic [COORD_BITS-1:0] py, logic [COORD_BITS-1:0] pz,
                             logic [LABEL_W-1:0] lbl);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({lbl, pz, py});
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.note_word(pixel_inside(py, pz), lbl);
    endtask

    // Most settings aim the pixels around the axis line where it crosses the
    // plane, so that both sides of the cone surface are hit; the rest use
    // extreme register values with pixels spread over the whole range.
    task automatic random_cone();
        longint ax, ay, az, dx, dy, dz, run, span;
        if ($urandom_range(0, 4) != 0)
        begin
            ax = rand_signed(1 << 20);
            ay = rand_signed(1 << 20);
            az = rand_signed(1 << 20);
            dx = $urandom_range(1, 1 << 20);
            if ($urandom_range(0, 1) == 1)
                dx = -dx;
            span = (dx < 0) ? -dx : dx;
            dy = rand_signed(span);
            dz = rand_signed(span);
            run = $urandom_range(1, 1 << 19);
            if ($urandom_range(0, 5) == 0)
                run = -run;
            if (dx < 0)
                run = -run;
            aim_y  = ay + run * dy / dx;
            aim_z  = az + run * dz / dx;
            spread = ((run < 0) ? -run : run) * $urandom_range(1, 3);
            if (spread > (1 << 22))
                spread = 1 << 22;
            load_cone(COORD_BITS'(ax), COORD_BITS'(ay), COORD_BITS'(az),
                      COORD_BITS'(dx), COORD_BITS'(dy), COORD_BITS'(dz),
                      pick_cos_word(), COORD_BITS'(ax + run));
        end
        else
        begin
            aim_y  = 0;
            aim_z  = 0;
            spread = 1 << 23;
            load_cone(extreme_coord(), extreme_coord(), extreme_coord(),
                      extreme_coord(), extreme_coord(), extreme_coord(),
                      pick_cos_word(), extreme_coord());
        end
    endtask

    task automatic send_cone_pixels(int n);
        int                    pause_at;
        logic [COORD_BITS-1:0] py, pz;
        pause_at = -1;
        if (n > 2 && $urandom_range(0, 2) == 0)
            pause_at = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                pause_until_drained();
            if ($urandom_range(0, 4) == 0)
            begin
                py = COORD_BITS'($urandom);
                pz = COORD_BITS'($urandom);
            end
            else
            begin
                py = COORD_BITS'(aim_y + rand_signed(spread));
                pz = COORD_BITS'(aim_z + rand_signed(spread));
            end
            send_word(py, pz, LABEL_W'($urandom));
        end
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            else
                stall = draw_wait(recv_mode);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            sb.check_word(m_axis_tdata);
        end
    end

    initial
    begin
        int phase;
        int n;
        sb            = new();
        cycle_count   = 0;
        hold_request  = 0;
        cone_settings = 0;
        send_mode     = 2;
        recv_mode     = 1;
        aim_y         = 0;
        aim_z         = 0;
        spread        = 1;
        cone_cfg         = '0;
        cone_cfg.axis_x  = cmpt_pkg::AXIS_X_RST;
        cone_cfg.cos_sq  = cmpt_pkg::COS_SQ_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Settings after reset put the plane through the apex, so nothing
        // is inside; the first pixel sits on the apex itself.
        send_word('0, '0, LABEL_W'(5));
        send_word(COORD_MAX, COORD_MIN, LABEL_W'(15));
        send_word(COORD_MIN, COORD_MAX, LABEL_W'(0));
        send_word(COORD_BITS'(4096), COORD_BITS'(-4096), LABEL_W'(9));

        load_cone('0, '0, '0, COORD_BITS'(4096), '0, '0,
                  CFG_DATA_BITS'(cmpt_pkg::COS_SQ_RST), COORD_BITS'(40960));
        send_word('0, '0, LABEL_W'(15));
        send_word('0, '0, LABEL_W'(0));
        send_word('0, COORD_BITS'(18000), LABEL_W'(10));
        send_word(COORD_BITS'(18500), '0, LABEL_W'(7));
        send_word(COORD_MAX, COORD_MAX, LABEL_W'(3));
        send_word(COORD_MIN, COORD_MIN, LABEL_W'(12));

        // Widest differences, with a pixel exactly on the axis: with
        // cos-squared at one it lies on the surface, hence outside.
        load_cone(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                  CFG_DATA_BITS'(65536), COORD_MAX);
        send_word(COORD_MAX, COORD_MAX, LABEL_W'(6));
        send_word('0, '0, LABEL_W'(1));

        load_cone(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                  {7'h7f, 17'd0}, COORD_MAX);
        send_word(COORD_MAX, COORD_MAX, LABEL_W'(6));
        send_word(COORD_MIN, COORD_MIN, LABEL_W'(2));

        load_cone('0, '0, '0, '0, '0, '0, '0, COORD_BITS'(40960));
        send_word(COORD_BITS'(100), COORD_BITS'(100), LABEL_W'(4));
        send_word(COORD_MAX, COORD_MIN, LABEL_W'(8));

        load_cone('0, '0, '0, COORD_BITS'(4096), '0, '0, {7'h55, 17'h1ffff},
                  COORD_BITS'(40960));
        send_word('0, '0, LABEL_W'(11));

        load_cone('0, '0, '0, COORD_BITS'(4096), '0, '0,
                  CFG_DATA_BITS'(cmpt_pkg::COS_SQ_RST), COORD_BITS'(-40960));
        send_word('0, '0, LABEL_W'(13));

        phase = 0;
        while (sb.words_in < TOTAL_PIXELS)
        begin
            random_cone();
            send_mode = $urandom_range(0, 2);
            recv_mode = $urandom_range(0, 2);
            n = $urandom_range(60, 140);
            if (n > TOTAL_PIXELS - sb.words_in)
                n = TOTAL_PIXELS - sb.words_in;
            if (phase == 2)
            begin
                send_mode    = 0;
                hold_request = HOLD_CYCLES;
            end
            send_cone_pixels(n);
            phase++;
        end

        pause_until_drained();
        repeat (4 * NUM_STAGES) @(posedge clk);

        $display("Streamed %0d pixels through %0d cone settings: %0d inside, %0d outside.",
                 sb.words_in, cone_settings, sb.inside_words, sb.outside_words);
        $display("Covered apex hits, a zero axis, cos-squared of zero, one and above one, %s",
                 "and a long output hold that backed up the input.");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
